// File: rtl/core/msp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package msp_pkg;

  localparam int MAX_ROWS = 8;
  localparam int MAX_COLS = 8;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int DEPTH    = MAX_ROWS * MAX_COLS;
  localparam int DATA_W   = 32;
  localparam int SIZE_W   = 4;
  localparam int CFG_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = CFG_IDX_W'(1);

  typedef logic [1:0] pc_t;

  localparam pc_t PC_LOAD = 2'd0;
  localparam pc_t PC_READ = 2'd1;
  localparam pc_t PC_EVAL = 2'd2;
  localparam pc_t PC_FIN  = 2'd3;

  typedef enum logic [1:0] {
    WAIT_NONE = 2'd0,
    WAIT_IN   = 2'd1,
    WAIT_OUT  = 2'd2
  } wait_t;

  typedef enum logic [1:0] {
    COND_ALWAYS    = 2'd0,
    COND_NOT_FINAL = 2'd1,
    COND_SCAN_MORE = 2'd2
  } cond_t;

  typedef struct packed {
    wait_t wt;
    logic  load_en;
    logic  rd_en;
    logic  eval_en;
    logic  fin_en;
    cond_t cond;
    pc_t   tgt;
  } ucode_t;

  typedef struct packed {
    logic in_rdy;
    logic load_go;
    logic rd_go;
    logic eval_go;
    logic fin_go;
  } ctrl_t;

  typedef struct packed {
    logic in_fire;
    logic final_elem;
    logic slot_free;
    logic scan_more;
  } status_t;

  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v,
                                                 input logic [SIZE_W-1:0] limit);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > limit) begin
      r = limit;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/matrix_saddle_point_search_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Ports                                              | Word
// ---------+----------------------------------------------------+-------------------------
// in       | in_valid, in_ready, in_element_value               | one element, row-major
// out      | out_valid, out_ready, out_point_*, out_last_result | one saddle point/marker
// cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data          | row_count / col_count
//
// Loading takes one element per cycle while in_valid is high; the microcode load step
// repeats in place. The final element starts a scan with a read and an evaluate step
// per stored entry, then a finish step; no element is taken until the scan is through.
// Reset is synchronous; it sets both sizes to 8 and restarts loading.
// A stalled output holds the scan in its evaluate or finish step.

module matrix_saddle_point_search_core
  import msp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [DATA_W-1:0] in_element_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_point_value,
  output logic [SIZE_W-1:0]        out_point_row,
  output logic [SIZE_W-1:0]        out_point_col,
  output logic                     out_point_found,
  output logic                     out_last_result,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [SIZE_W-1:0]        cfg_data
);

  ctrl_t   ctrl;
  status_t status;

  assign cfg_ready = 1'b1;
  assign in_ready  = ctrl.in_rdy;

  msp_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl)
  );

  msp_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctrl             (ctrl),
    .status           (status),
    .in_valid         (in_valid),
    .in_element_value (in_element_value),
    .cfg_fire         (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_point_value  (out_point_value),
    .out_point_row    (out_point_row),
    .out_point_col    (out_point_col),
    .out_point_found  (out_point_found),
    .out_last_result  (out_last_result)
  );

endmodule

`default_nettype wire

// File: rtl/core/msp_ucode_rom.sv
`timescale 1ns / 1ps
`default_nettype none

module msp_ucode_rom
  import msp_pkg::*;
(
  input  pc_t    pc,
  output ucode_t word
);

  always_comb begin
    case (pc)
      PC_LOAD: word = '{wt: WAIT_IN, load_en: 1'b1, rd_en: 1'b0, eval_en: 1'b0,
                        fin_en: 1'b0, cond: COND_NOT_FINAL, tgt: PC_LOAD};
      PC_READ: word = '{wt: WAIT_NONE, load_en: 1'b0, rd_en: 1'b1, eval_en: 1'b0,
                        fin_en: 1'b0, cond: COND_ALWAYS, tgt: PC_EVAL};
      PC_EVAL: word = '{wt: WAIT_OUT, load_en: 1'b0, rd_en: 1'b0, eval_en: 1'b1,
                        fin_en: 1'b0, cond: COND_SCAN_MORE, tgt: PC_READ};
      PC_FIN:  word = '{wt: WAIT_OUT, load_en: 1'b0, rd_en: 1'b0, eval_en: 1'b0,
                        fin_en: 1'b1, cond: COND_ALWAYS, tgt: PC_LOAD};
      default: word = '{wt: WAIT_NONE, load_en: 1'b0, rd_en: 1'b0, eval_en: 1'b0,
                        fin_en: 1'b0, cond: COND_ALWAYS, tgt: PC_LOAD};
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/msp_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module msp_seq
  import msp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  status_t status,
  output ctrl_t   ctrl
);

  pc_t    pc_r, pc_nxt;
  ucode_t word;
  logic   stall;
  logic   take;

  msp_ucode_rom u_rom (
    .pc   (pc_r),
    .word (word)
  );

  always_comb begin
    case (word.wt)
      WAIT_IN:  stall = !status.in_fire;
      WAIT_OUT: stall = !status.slot_free;
      default:  stall = 1'b0;
    endcase
  end

  always_comb begin
    case (word.cond)
      COND_ALWAYS:    take = 1'b1;
      COND_NOT_FINAL: take = !status.final_elem;
      COND_SCAN_MORE: take = status.scan_more;
      default:        take = 1'b1;
    endcase
  end

  always_comb begin
    ctrl.in_rdy  = (word.wt == WAIT_IN);
    ctrl.load_go = word.load_en && !stall;
    ctrl.rd_go   = word.rd_en && !stall;
    ctrl.eval_go = word.eval_en && !stall;
    ctrl.fin_go  = word.fin_en && !stall;
  end

  always_comb begin
    if (stall) begin
      pc_nxt = pc_r;
    end else if (take) begin
      pc_nxt = word.tgt;
    end else begin
      pc_nxt = pc_r + pc_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_LOAD;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/msp_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module msp_datapath
  import msp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  ctrl_t                    ctrl,
  output status_t                  status,
  input  logic                     in_valid,
  input  logic signed [DATA_W-1:0] in_element_value,
  input  logic                     cfg_fire,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [SIZE_W-1:0]        cfg_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_point_value,
  output logic [SIZE_W-1:0]        out_point_row,
  output logic [SIZE_W-1:0]        out_point_col,
  output logic                     out_point_found,
  output logic                     out_last_result
);

  logic [SIZE_W-1:0] rows_r, cols_r;
  logic [SIZE_W-1:0] rows_eff, cols_eff;

  logic [ROW_W-1:0] ld_row_r;
  logic [COL_W-1:0] ld_col_r;
  logic signed [DATA_W-1:0] run_min_r;

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] row_min_r [MAX_ROWS];
  logic signed [DATA_W-1:0] col_max_r [MAX_COLS];
  logic signed [DATA_W-1:0] rd_data_r;

  logic [ROW_W-1:0] scan_row_r;
  logic [COL_W-1:0] scan_col_r;

  logic                     pend_v_r;
  logic signed [DATA_W-1:0] pend_val_r;
  logic [ROW_W-1:0]         pend_row_r;
  logic [COL_W-1:0]         pend_col_r;

  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_val_r;
  logic [SIZE_W-1:0]        out_row_r, out_col_r;
  logic                     out_found_r, out_last_r;

  logic [ROW_W-1:0] r_use;
  logic [COL_W-1:0] c_use;
  logic             restart;
  logic             c_last, r_last;
  logic signed [DATA_W-1:0] new_min;
  logic [COL_W-1:0] cm_idx;
  logic signed [DATA_W-1:0] cm_rd;
  logic             hit;
  logic             scan_col_last, scan_row_last;
  logic             cfg_hit;

  assign rows_eff = eff_size(rows_r, SIZE_W'(MAX_ROWS));
  assign cols_eff = eff_size(cols_r, SIZE_W'(MAX_COLS));

  assign restart = ({1'b0, ld_row_r} >= rows_eff) || ({1'b0, ld_col_r} >= cols_eff);
  assign r_use   = restart ? '0 : ld_row_r;
  assign c_use   = restart ? '0 : ld_col_r;
  assign c_last  = ({1'b0, c_use} == cols_eff - SIZE_W'(1));
  assign r_last  = ({1'b0, r_use} == rows_eff - SIZE_W'(1));

  assign new_min = (c_use == '0 || in_element_value < run_min_r) ? in_element_value
                                                                 : run_min_r;

  assign cm_idx = ctrl.in_rdy ? c_use : scan_col_r;
  assign cm_rd  = col_max_r[cm_idx];

  assign hit = (rd_data_r == row_min_r[scan_row_r]) && (rd_data_r == cm_rd);

  assign scan_col_last = ({1'b0, scan_col_r} == cols_eff - SIZE_W'(1));
  assign scan_row_last = ({1'b0, scan_row_r} == rows_eff - SIZE_W'(1));

  assign cfg_hit = cfg_fire && (cfg_index == REG_ROW_COUNT || cfg_index == REG_COL_COUNT);

  always_comb begin
    status.in_fire    = in_valid && ctrl.in_rdy;
    status.final_elem = c_last && r_last;
    status.slot_free  = !out_valid_r || out_ready;
    status.scan_more  = !(scan_col_last && scan_row_last);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= SIZE_W'(MAX_ROWS);
      cols_r <= SIZE_W'(MAX_COLS);
    end else if (cfg_fire) begin
      if (cfg_index == REG_ROW_COUNT) begin
        rows_r <= cfg_data;
      end
      if (cfg_index == REG_COL_COUNT) begin
        cols_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ld_row_r  <= '0;
      ld_col_r  <= '0;
      run_min_r <= '0;
    end else if (cfg_hit) begin
      ld_row_r  <= '0;
      ld_col_r  <= '0;
      run_min_r <= '0;
    end else if (ctrl.load_go) begin
      if (!c_last) begin
        ld_row_r  <= r_use;
        ld_col_r  <= c_use + COL_W'(1);
        run_min_r <= new_min;
      end else if (!r_last) begin
        ld_row_r  <= r_use + ROW_W'(1);
        ld_col_r  <= '0;
        run_min_r <= new_min;
      end else begin
        ld_row_r  <= '0;
        ld_col_r  <= '0;
        run_min_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_go) begin
      mem[{r_use, c_use}] <= in_element_value;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd_go) begin
      rd_data_r <= mem[{scan_row_r, scan_col_r}];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_go) begin
      if (r_use == '0 || in_element_value > cm_rd) begin
        col_max_r[c_use] <= in_element_value;
      end
      if (c_last) begin
        row_min_r[r_use] <= new_min;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_go && c_last && r_last) begin
      scan_row_r <= '0;
      scan_col_r <= '0;
    end else if (ctrl.eval_go) begin
      if (scan_col_last) begin
        scan_col_r <= '0;
        scan_row_r <= scan_row_r + ROW_W'(1);
      end else begin
        scan_col_r <= scan_col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
    end else if (ctrl.eval_go && hit) begin
      pend_v_r <= 1'b1;
    end else if (ctrl.fin_go) begin
      pend_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.eval_go && hit) begin
      pend_val_r <= rd_data_r;
      pend_row_r <= scan_row_r;
      pend_col_r <= scan_col_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((ctrl.eval_go && hit && pend_v_r) || ctrl.fin_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.eval_go && hit && pend_v_r) begin
      out_val_r   <= pend_val_r;
      out_row_r   <= SIZE_W'(pend_row_r) + SIZE_W'(1);
      out_col_r   <= SIZE_W'(pend_col_r) + SIZE_W'(1);
      out_found_r <= 1'b1;
      out_last_r  <= 1'b0;
    end else if (ctrl.fin_go) begin
      out_last_r <= 1'b1;
      if (pend_v_r) begin
        out_val_r   <= pend_val_r;
        out_row_r   <= SIZE_W'(pend_row_r) + SIZE_W'(1);
        out_col_r   <= SIZE_W'(pend_col_r) + SIZE_W'(1);
        out_found_r <= 1'b1;
      end else begin
        out_val_r   <= '0;
        out_row_r   <= '0;
        out_col_r   <= '0;
        out_found_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_point_value = out_val_r;
  assign out_point_row   = out_row_r;
  assign out_point_col   = out_col_r;
  assign out_point_found = out_found_r;
  assign out_last_result = out_last_r;

endmodule

`default_nettype wire

// File: rtl/core/msp_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module msp_checker
  import msp_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [DATA_W-1:0] out_point_value,
  input logic [SIZE_W-1:0]        out_point_row,
  input logic [SIZE_W-1:0]        out_point_col,
  input logic                     out_point_found,
  input logic                     out_last_result,
  input logic                     in_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_point_value)
      && $stable(out_point_row) && $stable(out_point_col)
      && $stable(out_point_found) && $stable(out_last_result))
    else $error("output word changed while stalled");

  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_point_found |-> out_last_result && out_point_value == '0
      && out_point_row == '0 && out_point_col == '0)
    else $error("malformed not-found marker");

  a_point_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_point_found |-> out_point_row != '0 && out_point_col != '0
      && out_point_row <= SIZE_W'(MAX_ROWS) && out_point_col <= SIZE_W'(MAX_COLS))
    else $error("saddle point position out of range");

  a_no_load_mid_scan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_result |-> !in_ready)
    else $error("input taken before the scan finished");

endmodule

bind matrix_saddle_point_search_core msp_checker u_msp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_point_value (out_point_value),
  .out_point_row   (out_point_row),
  .out_point_col   (out_point_col),
  .out_point_found (out_point_found),
  .out_last_result (out_last_result),
  .in_ready        (in_ready)
);

`default_nettype wire
